// ----- src/pfc_pkg.sv -----
// Shared types, codes and constants of the pixel format converter.
package pfc_pkg;

   localparam int MAX_WIDTH_DEF     = 4096;
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int JOB_BYTES         = 6;
   localparam int FIFO_DEPTH        = 4;

   localparam logic [2:0] SRC_1BPP  = 3'd0;
   localparam logic [2:0] SRC_4BPP  = 3'd1;
   localparam logic [2:0] SRC_8BPP  = 3'd2;
   localparam logic [2:0] SRC_16BPP = 3'd3;
   localparam logic [2:0] SRC_24BPP = 3'd4;
   localparam logic [2:0] SRC_32BPP = 3'd5;

   localparam logic [2:0] DST_1BPP  = 3'd0;
   localparam logic [2:0] DST_4BPP  = 3'd1;
   localparam logic [2:0] DST_8BPP  = 3'd2;
   localparam logic [2:0] DST_15BPP = 3'd3;
   localparam logic [2:0] DST_16BPP = 3'd4;
   localparam logic [2:0] DST_24BPP = 3'd5;
   localparam logic [2:0] DST_32BPP = 3'd6;

   localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0] REG_DEST_FORMAT   = 2'd1;
   localparam logic [1:0] REG_ROW_WIDTH     = 2'd2;

   localparam logic [2:0]  SOURCE_FORMAT_RESET = SRC_8BPP;
   localparam logic [2:0]  DEST_FORMAT_RESET   = DST_32BPP;
   localparam logic [12:0] ROW_WIDTH_RESET     = 13'd1;

   localparam logic ACT_CONVERT   = 1'b0;
   localparam logic ACT_PAL_WRITE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] pixel_code;
      logic [7:0]  palette_index;
      logic [31:0] palette_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_row;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  source_format;
      logic [2:0]  dest_format;
      logic [12:0] row_width;
   } cfg_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      eor;
   } job_type;

endpackage

// ----- src/pfc_front.sv -----
// Front end: accepts items, holds the palette, converts pixels and packs rows into byte jobs.
module pfc_front #(
   parameter int MAX_WIDTH     = pfc_pkg::MAX_WIDTH_DEF,
   parameter int PALETTE_DEPTH = pfc_pkg::PALETTE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pfc_pkg::cfg_type cfg,
   input  logic             cfg_clear,
   input  logic             req_push,
   input  pfc_pkg::req_type req_data,
   output logic             req_full,
   output logic             job_push,
   output pfc_pkg::job_type job_data,
   input  logic             job_full
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (COL_W > 13) ? COL_W : 13;

   logic [31:0] palette_mem [PALETTE_DEPTH];

   logic             s1_valid_ff, s1_valid_in;
   pfc_pkg::req_type s1_req_ff;
   logic [31:0]      pal_rd_ff;
   logic             pal_hit_ff;

   logic [7:0]       acc_ff, acc_in;
   logic [2:0]       fill_ff, fill_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       phase_ff, phase_in;

   logic       accept, go, is_conv;
   logic [7:0] rd_index;
   logic       rd_hit, wr_hit;
   logic [2:0] job_cnt;

   assign accept = req_push && !req_full;

   always_comb begin
      case (cfg.source_format)
         pfc_pkg::SRC_1BPP: rd_index = {7'd0, req_data.pixel_code[0]};
         pfc_pkg::SRC_4BPP: rd_index = {4'd0, req_data.pixel_code[3:0]};
         default:           rd_index = req_data.pixel_code[7:0];
      endcase
   end

   assign rd_hit = {1'b0, rd_index} < 9'(PALETTE_DEPTH);
   assign wr_hit = {1'b0, req_data.palette_index} < 9'(PALETTE_DEPTH);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_data;
         pal_rd_ff  <= palette_mem[rd_index[PAL_AW-1:0]];
         pal_hit_ff <= rd_hit;
         if (req_data.action == pfc_pkg::ACT_PAL_WRITE && wr_hit) begin
            palette_mem[req_data.palette_index[PAL_AW-1:0]] <= req_data.palette_value;
         end
      end
   end

   // conversion stage
   logic [2:0]       sf, df;
   logic [31:0]      code, tc, colour;
   logic             indexed, mono;
   logic [7:0]       index, g332, tr, tg, tb, acc_tmp;
   logic [11:0]      r12, g12, b12, grey_sum;
   logic [3:0]       grey, fill_sum;
   logic [15:0]      w16;
   logic [3:0][7:0]  pix;
   logic [2:0]       npix, nbody, count;
   logic [7:0]       acc_next;
   logic [2:0]       fill_next;
   logic [COL_W-1:0] col_sum;
   logic [CMP_W-1:0] rw_ext, width_eff;
   logic             row_end, flush;
   logic [1:0]       phase_sum, pad;
   pfc_pkg::job_type job;

   always_comb begin
      sf      = cfg.source_format;
      df      = cfg.dest_format;
      code    = s1_req_ff.pixel_code;
      indexed = sf <= pfc_pkg::SRC_8BPP;
      case (sf)
         pfc_pkg::SRC_1BPP: index = {7'd0, code[0]};
         pfc_pkg::SRC_4BPP: index = {4'd0, code[3:0]};
         default:           index = code[7:0];
      endcase
      case (sf)
         pfc_pkg::SRC_16BPP: tc = {(code[15] ? 8'h80 : 8'h00), code[14:10], 3'd0,
                                   code[9:5], 3'd0, code[4:0], 3'd0};
         pfc_pkg::SRC_24BPP: tc = {8'd0, code[23:0]};
         default:            tc = code;
      endcase
      if (indexed) begin
         mono = index[0];
      end else begin
         case (sf)
            pfc_pkg::SRC_16BPP: mono = |code[15:0];
            pfc_pkg::SRC_24BPP: mono = |code[23:0];
            default:            mono = |code;
         endcase
      end
      tr       = tc[23:16];
      tg       = tc[15:8];
      tb       = tc[7:0];
      r12      = {4'd0, tr};
      g12      = {4'd0, tg};
      b12      = {4'd0, tb};
      grey_sum = (g12 << 3) + g12 + (r12 << 2) + r12 + (b12 << 1);
      grey     = indexed ? index[3:0] : grey_sum[11:8];
      g332     = indexed ? index : {tg[7:5], tr[7:5], tb[7:6]};
      colour   = indexed ? (pal_hit_ff ? pal_rd_ff : 32'd0) : tc;
      w16      = {(df == pfc_pkg::DST_16BPP) && (|colour[31:24]),
                  colour[23:19], colour[15:11], colour[7:3]};

      pix       = '0;
      npix      = 3'd0;
      acc_next  = acc_ff;
      fill_next = fill_ff;
      acc_tmp   = 8'd0;
      fill_sum  = {1'b0, fill_ff} + 4'd1;
      case (df)
         pfc_pkg::DST_1BPP: begin
            acc_tmp = acc_ff | ({7'd0, mono} << (3'd7 - fill_ff));
            if (fill_sum == 4'd8) begin
               pix[0]    = acc_tmp;
               npix      = 3'd1;
               acc_next  = 8'd0;
               fill_next = 3'd0;
            end else begin
               acc_next  = acc_tmp;
               fill_next = fill_sum[2:0];
            end
         end
         pfc_pkg::DST_4BPP: begin
            acc_tmp = acc_ff | (fill_ff[0] ? {4'd0, grey} : {grey, 4'd0});
            if (fill_sum >= 4'd2) begin
               pix[0]    = acc_tmp;
               npix      = 3'd1;
               acc_next  = 8'd0;
               fill_next = 3'd0;
            end else begin
               acc_next  = acc_tmp;
               fill_next = fill_sum[2:0];
            end
         end
         pfc_pkg::DST_8BPP: begin
            pix[0] = g332;
            npix   = 3'd1;
         end
         pfc_pkg::DST_15BPP, pfc_pkg::DST_16BPP: begin
            pix[0] = w16[7:0];
            pix[1] = w16[15:8];
            npix   = 3'd2;
         end
         pfc_pkg::DST_24BPP: begin
            pix[0] = colour[7:0];
            pix[1] = colour[15:8];
            pix[2] = colour[23:16];
            npix   = 3'd3;
         end
         default: begin
            pix  = colour;
            pix  = {colour[31:24], colour[23:16], colour[15:8], colour[7:0]};
            npix = 3'd4;
         end
      endcase

      col_sum = col_ff + COL_W'(1);
      rw_ext  = CMP_W'(cfg.row_width);
      if (rw_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = rw_ext;
      end
      row_end   = CMP_W'(col_sum) >= width_eff;
      flush     = row_end && (fill_next != 3'd0);
      nbody     = npix + {2'd0, flush};
      phase_sum = phase_ff + nbody[1:0];
      pad       = row_end ? (2'd0 - phase_sum) : 2'd0;
      count     = nbody + {1'b0, pad};

      for (int k = 0; k < pfc_pkg::JOB_BYTES; k++) begin
         if (k < 4 && 3'(k) < npix) begin
            job.bytes[k] = pix[k[1:0]];
         end else if (flush && 3'(k) == npix) begin
            job.bytes[k] = acc_next;
         end else begin
            job.bytes[k] = 8'd0;
         end
      end
      job.count = count;
      job.eor   = row_end;
   end

   assign is_conv     = s1_req_ff.action == pfc_pkg::ACT_CONVERT;
   assign job_cnt     = is_conv ? count : 3'd0;
   assign go          = s1_valid_ff && ((job_cnt == 3'd0) || !job_full);
   assign req_full    = s1_valid_ff && !go;
   assign s1_valid_in = accept || (s1_valid_ff && !go);
   assign job_push    = go && (job_cnt != 3'd0);
   assign job_data    = job;

   always_comb begin
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      if (go && is_conv) begin
         if (row_end) begin
            acc_in   = 8'd0;
            fill_in  = 3'd0;
            col_in   = '0;
            phase_in = 2'd0;
         end else begin
            acc_in   = acc_next;
            fill_in  = fill_next;
            col_in   = col_sum;
            phase_in = phase_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= 8'd0;
         fill_ff     <= 3'd0;
         col_ff      <= '0;
         phase_ff    <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (cfg_clear) begin
            acc_ff   <= 8'd0;
            fill_ff  <= 3'd0;
            col_ff   <= '0;
            phase_ff <= 2'd0;
         end else begin
            acc_ff   <= acc_in;
            fill_ff  <= fill_in;
            col_ff   <= col_in;
            phase_ff <= phase_in;
         end
      end
   end

   a_job_count_range: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_data.count <= 3'(pfc_pkg::JOB_BYTES)))
      else $error("job byte count out of range");

   a_row_end_flags_last: assert property (@(posedge clock) disable iff (reset)
      (job_push && job_data.eor) |-> (phase_in == 2'd0 && col_in == '0))
      else $error("row end did not clear the row position");

endmodule

// ----- src/pfc_job_fifo.sv -----
// Short job queue between the front end and the byte serializer.
module pfc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfc_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output pfc_pkg::job_type pop_data,
   output logic             empty
);

   localparam int AW = $clog2(pfc_pkg::FIFO_DEPTH);

   pfc_pkg::job_type       slot_ff [pfc_pkg::FIFO_DEPTH];
   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW:0]            count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = count_ff == (AW+1)'(pfc_pkg::FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
   assign count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(pfc_pkg::FIFO_DEPTH))
      else $error("job queue count beyond depth");

endmodule

// ----- src/pfc_back.sv -----
// Back end: takes byte jobs from the queue and issues one result byte per cycle while popped.
module pfc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   output logic             job_pop,
   input  pfc_pkg::job_type job_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pfc_pkg::rsp_type rsp_data
);

   logic             cur_valid_ff, cur_valid_in;
   pfc_pkg::job_type cur_ff;
   logic [2:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   pfc_pkg::rsp_type out_ff, out_in;
   logic             out_load, cur_last, cur_done;

   assign out_load = cur_valid_ff && (!out_valid_ff || rsp_pop);
   assign cur_last = idx_ff == (cur_ff.count - 3'd1);
   assign cur_done = out_load && cur_last;
   assign job_pop  = !job_empty && (!cur_valid_ff || cur_done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (job_pop) begin
         cur_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (out_load) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      out_in.out_byte    = cur_ff.bytes[idx_ff];
      out_in.last_of_run = cur_last;
      out_in.end_of_row  = cur_last && cur_ff.eor;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job_data;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.count != 3'd0 && idx_ff < cur_ff.count))
      else $error("serializer index beyond job length");

endmodule

// ----- src/pixel_format_converter_core.sv -----
// Pixel format converter top level: CSR registers, front end, job queue and byte serializer.
// An item's first result byte passes the front-end stage, the job queue and the serializer's
// current-job and output registers. Throughput: one item accepted per cycle into the front
// end while the job queue has room; results leave one byte per cycle while popped, and an
// item yields 0 to 6 bytes (4 for 32 bpp pixels). Reset clears the CSRs to their defaults
// and the packing and row position; the palette is not cleared and holds garbage until written.
module pixel_format_converter_core #(
   parameter int MAX_WIDTH     = pfc_pkg::MAX_WIDTH_DEF,
   parameter int PALETTE_DEPTH = pfc_pkg::PALETTE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  pfc_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pfc_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [2:0]       src_fmt_ff, src_fmt_in;
   logic [2:0]       dst_fmt_ff, dst_fmt_in;
   logic [12:0]      row_width_ff, row_width_in;
   logic             csr_write, cfg_clear;
   logic [1:0]       csr_index;
   pfc_pkg::cfg_type cfg;

   logic             job_push, job_full, job_pop, job_empty;
   pfc_pkg::job_type job_in_data, job_out_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      src_fmt_in   = src_fmt_ff;
      dst_fmt_in   = dst_fmt_ff;
      row_width_in = row_width_ff;
      cfg_clear    = 1'b0;
      if (csr_write) begin
         case (csr_index)
            pfc_pkg::REG_SOURCE_FORMAT: begin
               src_fmt_in = csr_pwdata[2:0];
               cfg_clear  = 1'b1;
            end
            pfc_pkg::REG_DEST_FORMAT: begin
               dst_fmt_in = csr_pwdata[2:0];
               cfg_clear  = 1'b1;
            end
            pfc_pkg::REG_ROW_WIDTH: begin
               row_width_in = csr_pwdata[12:0];
               cfg_clear    = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pfc_pkg::REG_SOURCE_FORMAT: csr_prdata = {29'd0, src_fmt_ff};
         pfc_pkg::REG_DEST_FORMAT:   csr_prdata = {29'd0, dst_fmt_ff};
         pfc_pkg::REG_ROW_WIDTH:     csr_prdata = {19'd0, row_width_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff   <= pfc_pkg::SOURCE_FORMAT_RESET;
         dst_fmt_ff   <= pfc_pkg::DEST_FORMAT_RESET;
         row_width_ff <= pfc_pkg::ROW_WIDTH_RESET;
      end else begin
         src_fmt_ff   <= src_fmt_in;
         dst_fmt_ff   <= dst_fmt_in;
         row_width_ff <= row_width_in;
      end
   end

   assign cfg.source_format = src_fmt_ff;
   assign cfg.dest_format   = dst_fmt_ff;
   assign cfg.row_width     = row_width_ff;

   pfc_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_clear (cfg_clear),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .job_push  (job_push),
      .job_data  (job_in_data),
      .job_full  (job_full)
   );

   pfc_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   pfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_data  (job_out_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/tb_pixel_format_converter_core.sv -----
// Self-checking testbench for the pixel format converter core: directed table, then random.
module tb_pixel_format_converter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ROW_LIMIT   = pfc_pkg::MAX_WIDTH_DEF;
   localparam int          DRAIN_WAIT  = 8;
   localparam int          END_WAIT    = 20;
   localparam int          QUIET_LIMIT = 5000;
   localparam int          SEGMENTS    = 24;
   localparam logic [1:0]  REG_SPARE   = 2'd3;
   localparam logic [2:0]  SRC_UNUSED  = 3'd7;
   localparam logic [2:0]  DST_UNUSED  = 3'd7;
   localparam logic [12:0] WIDTH_ALL   = 13'h1FFF;

   typedef struct {
      bit               is_cfg;
      logic [1:0]       reg_idx;
      logic [31:0]      reg_val;
      pfc_pkg::req_type item;
      int               n_typed;
      logic [47:0]      typed;
   } stim_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   pfc_pkg::req_type req_data    = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   pfc_pkg::rsp_type rsp_data;
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [3:0]       csr_paddr   = '0;
   logic [31:0]      csr_pwdata  = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // converter state as predicted
   logic [2:0]  src_fmt = pfc_pkg::SOURCE_FORMAT_RESET;
   logic [2:0]  dst_fmt = pfc_pkg::DEST_FORMAT_RESET;
   logic [12:0] row_w   = pfc_pkg::ROW_WIDTH_RESET;
   bit [31:0]   palette_mem    [pfc_pkg::PALETTE_DEPTH_DEF];
   bit          palette_loaded [pfc_pkg::PALETTE_DEPTH_DEF];
   logic [7:0]  pack_acc  = '0;
   int          pack_fill = 0;
   int          col_count = 0;
   int          row_phase = 0;

   pfc_pkg::rsp_type run_expect[$];
   pfc_pkg::rsp_type expected_bytes[$];
   stim_row_type     directed[$];

   int tx_idle_pct = 36;
   int rx_idle_pct = 78;
   int errors = 0, items_sent = 0, pal_writes = 0, bytes_checked = 0;
   int rows_closed = 0, csr_writes = 0, quiet = 0;

   pixel_format_converter_core DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic void clear_row();
      pack_acc  = '0;
      pack_fill = 0;
      col_count = 0;
      row_phase = 0;
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      pfc_pkg::rsp_type rs;
      rs = '{out_byte: b, last_of_run: 1'b0, end_of_row: 1'b0};
      run_expect.push_back(rs);
      row_phase = (row_phase + 1) % 4;
   endfunction

   function automatic logic [7:0] src_index(logic [31:0] code);
      return code[7:0] & ((src_fmt == pfc_pkg::SRC_1BPP) ? 8'h01 :
                          (src_fmt == pfc_pkg::SRC_4BPP) ? 8'h0F : 8'hFF);
   endfunction

   // fills run_expect with the bytes one item yields and advances the row state
   function automatic void predict_run(pfc_pkg::req_type it);
      logic             indexed, mono, row_closed;
      logic [7:0]       idx, r, g, b;
      logic [31:0]      code, color;
      logic [15:0]      hw;
      int               width, grey;
      pfc_pkg::rsp_type tail;
      run_expect.delete();
      code = it.pixel_code;
      if (it.action == pfc_pkg::ACT_PAL_WRITE) begin
         palette_mem[it.palette_index]    = it.palette_value;
         palette_loaded[it.palette_index] = 1'b1;
         return;
      end
      width   = (row_w == 0) ? 1 : (row_w > ROW_LIMIT) ? ROW_LIMIT : int'(row_w);
      indexed = (src_fmt <= pfc_pkg::SRC_8BPP);
      idx     = src_index(code);
      case (src_fmt)
         pfc_pkg::SRC_1BPP, pfc_pkg::SRC_4BPP, pfc_pkg::SRC_8BPP: color = palette_mem[idx];
         pfc_pkg::SRC_16BPP: color = {code[15] ? 8'h80 : 8'h00, code[14:10], 3'b000,
                                      code[9:5], 3'b000, code[4:0], 3'b000};
         pfc_pkg::SRC_24BPP: color = {8'h00, code[23:0]};
         default:            color = code;
      endcase
      r = color[23:16];
      g = color[15:8];
      b = color[7:0];
      case (dst_fmt)
         pfc_pkg::DST_1BPP: begin
            mono = indexed ? idx[0] : (src_fmt == pfc_pkg::SRC_16BPP) ? |code[15:0]
                 : (src_fmt == pfc_pkg::SRC_24BPP) ? |code[23:0] : |code;
            pack_acc[7 - pack_fill] = mono;
            pack_fill++;
            if (pack_fill == 8) begin
               emit_byte(pack_acc);
               pack_acc  = '0;
               pack_fill = 0;
            end
         end
         pfc_pkg::DST_4BPP: begin
            grey = indexed ? int'(idx[3:0]) : ((9 * g + 5 * r + 2 * b) >> 8) & 15;
            if (pack_fill == 0) pack_acc[7:4] = grey[3:0];
            else pack_acc[3:0] = grey[3:0];
            pack_fill++;
            if (pack_fill == 2) begin
               emit_byte(pack_acc);
               pack_acc  = '0;
               pack_fill = 0;
            end
         end
         pfc_pkg::DST_8BPP: begin
            emit_byte(indexed ? idx : {g[7:5], r[7:5], b[7:6]});
         end
         pfc_pkg::DST_15BPP, pfc_pkg::DST_16BPP: begin
            hw = {(dst_fmt == pfc_pkg::DST_16BPP) && (color[31:24] != 0),
                  r[7:3], g[7:3], b[7:3]};
            emit_byte(hw[7:0]);
            emit_byte(hw[15:8]);
         end
         default: begin
            emit_byte(color[7:0]);
            emit_byte(color[15:8]);
            emit_byte(color[23:16]);
            if (dst_fmt != pfc_pkg::DST_24BPP) emit_byte(color[31:24]);
         end
      endcase
      col_count++;
      row_closed = (col_count >= width);
      if (row_closed) begin
         if (pack_fill != 0) emit_byte(pack_acc);
         while (row_phase != 0) emit_byte(8'h00);
         rows_closed++;
         clear_row();
      end
      if (run_expect.size() != 0) begin
         tail = run_expect.pop_back();
         tail.last_of_run = 1'b1;
         tail.end_of_row  = row_closed;
         run_expect.push_back(tail);
      end
   endfunction

   function automatic void add_cfg(logic [1:0] idx, logic [31:0] val);
      stim_row_type row;
      row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, item: '0, n_typed: -1, typed: '0};
      directed.push_back(row);
   endfunction

   function automatic void add_item(logic act, logic [31:0] code, logic [7:0] pidx,
                                    logic [31:0] pval, int n_typed = -1,
                                    logic [47:0] typed = '0);
      stim_row_type row;
      row.is_cfg  = 1'b0;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.item    = '{action: act, pixel_code: code, palette_index: pidx, palette_value: pval};
      row.n_typed = n_typed;
      row.typed   = typed;
      directed.push_back(row);
   endfunction

   task automatic send_item(pfc_pkg::req_type it, int n_typed = -1, logic [47:0] typed = '0);
      pfc_pkg::rsp_type rs;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (it.action == pfc_pkg::ACT_PAL_WRITE) pal_writes++;
      predict_run(it);
      if (n_typed >= 0) begin
         run_expect.delete();
         for (int k = 0; k < n_typed; k++) begin
            rs.out_byte    = typed[47 - 8 * k -: 8];
            rs.last_of_run = (k == n_typed - 1);
            rs.end_of_row  = (k == n_typed - 1);
            run_expect.push_back(rs);
         end
      end
      foreach (run_expect[k]) expected_bytes.push_back(run_expect[k]);
   endtask

   task automatic wait_drained(int settle);
      req_push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // write one register, then read it back unless it is the spare register
   task automatic write_register(logic [1:0] idx, logic [31:0] val);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_writes++;
      case (idx)
         pfc_pkg::REG_SOURCE_FORMAT: src_fmt = val[2:0];
         pfc_pkg::REG_DEST_FORMAT:   dst_fmt = val[2:0];
         pfc_pkg::REG_ROW_WIDTH:     row_w   = val[12:0];
         default: ;
      endcase
      if (idx == REG_SPARE) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
      end else begin
         clear_row();
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         case (idx)
            pfc_pkg::REG_SOURCE_FORMAT: want = {29'd0, src_fmt};
            pfc_pkg::REG_DEST_FORMAT:   want = {29'd0, dst_fmt};
            default:                    want = {19'd0, row_w};
         endcase
         if (csr_prdata !== want) begin
            $error("csr_prdata[%0d]: expected %h, got %h", idx, want, csr_prdata);
            errors++;
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   always @(posedge clock) begin : result_check
      pfc_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_bytes.size() == 0) begin
            $error("result with nothing expected: out_byte %h", rsp_data.out_byte);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               errors++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run,
                      rsp_data.last_of_run);
               errors++;
            end
            if (rsp_data.end_of_row !== want.end_of_row) begin
               $error("end_of_row: expected %b, got %b", want.end_of_row, rsp_data.end_of_row);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("pixel_format_converter_core regression: fail");
            $finish;
         end
      end
   end

   initial begin
      pfc_pkg::req_type it;
      pfc_pkg::req_type pal;
      logic [7:0]       pidx;
      logic [12:0]      width;
      int               n;

      add_item(pfc_pkg::ACT_PAL_WRITE, 32'h0, 8'h00, 32'h0000_0000);
      add_item(pfc_pkg::ACT_PAL_WRITE, 32'h0, 8'hFF, 32'hFFFF_FFFF);
      add_item(pfc_pkg::ACT_PAL_WRITE, 32'h0, 8'h5A, 32'h1234_5678);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_00FF, 8'h00, 32'h0, 4, 48'hFFFFFFFF_0000);
      add_item(pfc_pkg::ACT_CONVERT, 32'hFFFF_FF00, 8'h00, 32'h0, 4, 48'h00000000_0000);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_005A, 8'h00, 32'h0, 4, 48'h78563412_0000);
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(pfc_pkg::DST_24BPP));
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_005A, 8'h00, 32'h0, 4, 48'h78563400_0000);
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(pfc_pkg::DST_16BPP));
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_00FF, 8'h00, 32'h0, 4, 48'hFFFF0000_0000);
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(pfc_pkg::DST_15BPP));
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_00FF, 8'h00, 32'h0, 4, 48'hFF7F0000_0000);
      add_cfg(pfc_pkg::REG_SOURCE_FORMAT, 32'(pfc_pkg::SRC_1BPP));
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(pfc_pkg::DST_1BPP));
      add_cfg(pfc_pkg::REG_ROW_WIDTH, 32'd8);
      for (int i = 0; i < 8; i++)
         add_item(pfc_pkg::ACT_CONVERT, (i % 3 == 0) ? 32'hFFFF_FFFF : i, 8'h00, 32'h0);
      add_cfg(pfc_pkg::REG_SOURCE_FORMAT, 32'(pfc_pkg::SRC_32BPP));
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(pfc_pkg::DST_8BPP));
      add_cfg(pfc_pkg::REG_ROW_WIDTH, 32'd0);
      add_item(pfc_pkg::ACT_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0, 4, 48'hFF000000_0000);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_0000, 8'h00, 32'h0, 4, 48'h00000000_0000);
      add_cfg(pfc_pkg::REG_SOURCE_FORMAT, 32'(pfc_pkg::SRC_16BPP));
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(pfc_pkg::DST_4BPP));
      add_cfg(pfc_pkg::REG_ROW_WIDTH, 32'd3);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_8000, 8'h00, 32'h0);
      add_cfg(REG_SPARE, 32'hFFFF_FFFF);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_7FFF, 8'h00, 32'h0);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0000_FFFF, 8'h00, 32'h0);
      add_cfg(pfc_pkg::REG_SOURCE_FORMAT, 32'(SRC_UNUSED));
      add_cfg(pfc_pkg::REG_DEST_FORMAT, 32'(DST_UNUSED));
      add_cfg(pfc_pkg::REG_ROW_WIDTH, 32'd2);
      add_item(pfc_pkg::ACT_CONVERT, 32'hDEAD_BEEF, 8'h00, 32'h0);
      add_item(pfc_pkg::ACT_CONVERT, 32'h0123_4567, 8'h00, 32'h0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg) begin
            wait_drained(DRAIN_WAIT);
            write_register(directed[i].reg_idx, directed[i].reg_val);
         end else begin
            send_item(directed[i].item, directed[i].n_typed, directed[i].typed);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained(DRAIN_WAIT);
         if (seg < SEGMENTS / 3) begin
            tx_idle_pct = 36;
            rx_idle_pct = 78;
         end else if (seg < 2 * SEGMENTS / 3) begin
            tx_idle_pct = 78;
            rx_idle_pct = 36;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case ($urandom_range(9))
            0:       width = '0;
            1:       width = 13'(ROW_LIMIT);
            2:       width = WIDTH_ALL;
            3:       width = 13'($urandom_range(1, WIDTH_ALL));
            default: width = 13'($urandom_range(1, 9));
         endcase
         write_register(pfc_pkg::REG_SOURCE_FORMAT, seg % 8);
         write_register(pfc_pkg::REG_DEST_FORMAT, (seg + seg / 8) % 8);
         write_register(pfc_pkg::REG_ROW_WIDTH, {19'd0, width});
         n = $urandom_range(10, 22);
         repeat (n) begin
            it.action        = ($urandom_range(99) < 15) ? pfc_pkg::ACT_PAL_WRITE
                                                          : pfc_pkg::ACT_CONVERT;
            it.palette_index = 8'($urandom);
            it.palette_value = $urandom;
            case ($urandom_range(9))
               0:       it.pixel_code = '0;
               1:       it.pixel_code = '1;
               2:       it.pixel_code = $urandom & 32'hFFFF_0000;
               default: it.pixel_code = $urandom;
            endcase
            pidx = src_index(it.pixel_code);
            if (it.action == pfc_pkg::ACT_CONVERT && src_fmt <= pfc_pkg::SRC_8BPP
                && dst_fmt >= pfc_pkg::DST_15BPP && !palette_loaded[pidx]) begin
               pal = '{action: pfc_pkg::ACT_PAL_WRITE, pixel_code: $urandom,
                       palette_index: pidx, palette_value: $urandom};
               send_item(pal);
            end
            send_item(it);
         end
      end

      wait_drained(END_WAIT);
      $display("covered %0d items (%0d palette writes), %0d register writes",
               items_sent, pal_writes, csr_writes);
      $display("checked %0d result bytes over %0d closed rows", bytes_checked, rows_closed);
      if (errors == 0)
         $display("pixel_format_converter_core regression: pass");
      else
         $display("pixel_format_converter_core regression: fail");
      $finish;
   end

endmodule

// ----- pixel_format_converter_core.f -----
src/pfc_pkg.sv
src/pfc_front.sv
src/pfc_job_fifo.sv
src/pfc_back.sv
src/pixel_format_converter_core.sv
dv/tb_pixel_format_converter_core.sv
